// File: rtl/drop_oldest_frame_queue_macros.svh
// assertion macros for the frame queue checker
`ifndef DROP_OLDEST_FRAME_QUEUE_MACROS_SVH
`define DROP_OLDEST_FRAME_QUEUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define DOFQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("frame queue check failed");

// next-cycle implication, checked outside reset
`define DOFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("frame queue check failed");

`endif

// File: rtl/dofq_pkg.sv
`default_nettype none
package dofq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OCC_W       = 5;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned DROP_W      = 32;
  localparam int unsigned SMP_W       = 16;

  localparam logic ACT_PUBLISH = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } dofq_state_e;

  typedef struct packed {
    logic                    action;
    logic signed [SMP_W-1:0] accel_x;
    logic signed [SMP_W-1:0] accel_y;
    logic signed [SMP_W-1:0] accel_z;
    logic signed [SMP_W-1:0] gyro_x;
    logic signed [SMP_W-1:0] gyro_y;
    logic signed [SMP_W-1:0] gyro_z;
    logic signed [SMP_W-1:0] temperature;
  } dofq_in_t;

  typedef struct packed {
    logic                    frame_valid;
    logic [SEQ_W-1:0]        frame_seq;
    logic signed [SMP_W-1:0] out_accel_x;
    logic signed [SMP_W-1:0] out_accel_y;
    logic signed [SMP_W-1:0] out_accel_z;
    logic signed [SMP_W-1:0] out_gyro_x;
    logic signed [SMP_W-1:0] out_gyro_y;
    logic signed [SMP_W-1:0] out_gyro_z;
    logic signed [SMP_W-1:0] out_temperature;
    logic                    ready_res;
    logic [OCC_W-1:0]        occupancy;
    logic [DROP_W-1:0]       drop_total;
  } dofq_out_t;

  // one queue slot
  typedef struct packed {
    logic [SEQ_W-1:0]        seq;
    logic signed [SMP_W-1:0] temperature;
    logic signed [SMP_W-1:0] gyro_z;
    logic signed [SMP_W-1:0] gyro_y;
    logic signed [SMP_W-1:0] gyro_x;
    logic signed [SMP_W-1:0] accel_z;
    logic signed [SMP_W-1:0] accel_y;
    logic signed [SMP_W-1:0] accel_x;
  } dofq_entry_t;

  localparam int unsigned ENTRY_W = $bits(dofq_entry_t);

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    dofq_entry_t       wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } dofq_mem_req_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/drop_oldest_frame_queue.sv
// results: a publish or a read of an empty queue is registered into the result register at acceptance,
// a read that pops a frame goes through the slot memory read register, then the result register
// throughput: 1 publish per cycle unless output stalls; pops stall input for the slot read
// reset: asynchronous active low, clears pointers, fill count, sequence and drop counters;
// slot memory is not cleared and needs no clearing pass
`default_nettype none
module drop_oldest_frame_queue
  import dofq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dofq_in_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output dofq_out_t     out_data_o
);

  dofq_mem_req_t     mem_req;
  logic [ENTRY_W-1:0] mem_rdata;

  dofq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (dofq_entry_t'(mem_rdata))
  );

  dofq_ram #(
    .DATA_W (ENTRY_W),
    .ADDR_W (PTR_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

// File: rtl/dofq_ram.sv
`default_nettype none
module dofq_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DEPTH  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/dofq_ctrl.sv
`default_nettype none
module dofq_ctrl
  import dofq_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dofq_in_t      in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output dofq_out_t          out_data_o,
  output dofq_mem_req_t      mem_req_o,
  input  wire dofq_entry_t   mem_rdata_i
);

  dofq_state_e       state_q, state_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [DROP_W-1:0] drop_q, drop_d;
  logic              out_valid_q, out_valid_d;
  dofq_out_t         out_q, out_d;

  logic accept, is_pub, full, empty;
  logic load_now, load_mem;

  assign is_pub = (in_data_i.action == ACT_PUBLISH);
  assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);
  assign accept = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !is_pub && !empty) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall_o = 1'b1;
    load_mem   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // result register is free or drains this cycle
        in_stall_o = out_valid_q && out_stall_i;
      end
      ST_READ: begin
        load_mem = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // publishes and empty reads finish at acceptance
  assign load_now = accept && (is_pub || empty);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    seq_d    = seq_q;
    drop_d   = drop_q;
    if (accept) begin
      if (is_pub) begin
        seq_d    = seq_q + SEQ_W'(1);
        wr_ptr_d = next_ptr(wr_ptr_q);
        if (full) begin
          // overwrite the oldest slot
          drop_d   = drop_q + DROP_W'(1);
          rd_ptr_d = next_ptr(rd_ptr_q);
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end else if (!empty) begin
        rd_ptr_d = next_ptr(rd_ptr_q);
        count_d  = count_q - CNT_W'(1);
      end
    end
  end

  // the slot just written is read no earlier than the next cycle, so no bypass
  always_comb begin
    mem_req_o                   = '0;
    mem_req_o.we                = accept && is_pub;
    mem_req_o.waddr             = wr_ptr_q;
    mem_req_o.wdata.seq         = seq_d;
    mem_req_o.wdata.accel_x     = in_data_i.accel_x;
    mem_req_o.wdata.accel_y     = in_data_i.accel_y;
    mem_req_o.wdata.accel_z     = in_data_i.accel_z;
    mem_req_o.wdata.gyro_x      = in_data_i.gyro_x;
    mem_req_o.wdata.gyro_y      = in_data_i.gyro_y;
    mem_req_o.wdata.gyro_z      = in_data_i.gyro_z;
    mem_req_o.wdata.temperature = in_data_i.temperature;
    mem_req_o.re                = accept && !is_pub && !empty;
    mem_req_o.raddr             = rd_ptr_q;
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load_now) begin
      out_d            = '0;
      out_d.ready_res  = (count_d != '0);
      out_d.occupancy  = OCC_W'(count_d);
      out_d.drop_total = drop_d;
      out_valid_d      = 1'b1;
    end else if (load_mem) begin
      out_d.frame_valid     = 1'b1;
      out_d.frame_seq       = mem_rdata_i.seq;
      out_d.out_accel_x     = mem_rdata_i.accel_x;
      out_d.out_accel_y     = mem_rdata_i.accel_y;
      out_d.out_accel_z     = mem_rdata_i.accel_z;
      out_d.out_gyro_x      = mem_rdata_i.gyro_x;
      out_d.out_gyro_y      = mem_rdata_i.gyro_y;
      out_d.out_gyro_z      = mem_rdata_i.gyro_z;
      out_d.out_temperature = mem_rdata_i.temperature;
      out_d.ready_res       = (count_q != '0);
      out_d.occupancy       = OCC_W'(count_q);
      out_d.drop_total      = drop_q;
      out_valid_d           = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      seq_q       <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
      seq_q       <= seq_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: rtl/drop_oldest_frame_queue_checker.sv
`default_nettype none
`include "drop_oldest_frame_queue_macros.svh"
module drop_oldest_frame_queue_checker
  import dofq_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire dofq_in_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire dofq_out_t out_data_o
);

  logic in_beat;
  logic out_held;
  logic no_frame;

  assign in_beat  = in_valid_i && !in_stall_o && (in_data_i.action == ACT_READ);
  assign out_held = out_valid_o && out_stall_i;
  assign no_frame = out_valid_o && !out_data_o.frame_valid;

  // a held result stays put
  `DOFQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o)
  `DOFQ_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_held, $stable(out_data_o))

  // no popped frame means zeroed frame fields
  `DOFQ_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, no_frame, (out_data_o.frame_seq == '0) && (out_data_o.out_accel_x == '0) && (out_data_o.out_temperature == '0))

  // a valid result never reports an occupancy over the queue depth
  `DOFQ_ASSERT_NOW(a_occ_bound, clk_i, rst_ni, out_valid_o || in_beat, 32'(out_data_o.occupancy) <= 32'(QUEUE_DEPTH) || !out_valid_o)

endmodule

bind drop_oldest_frame_queue drop_oldest_frame_queue_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
